/* rtl/core/quaternion_tilt_angles_defines.svh */
// Assertion macros for the tilt angle block.
`ifndef QUATERNION_TILT_ANGLES_DEFINES_SVH
`define QUATERNION_TILT_ANGLES_DEFINES_SVH

`ifndef SYNTHESIS
`define QTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QTA_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define QTA_ASSERT(label, prop, msg)
`define QTA_NEVER(label, expr, msg)
`endif

`endif

/* rtl/core/qta_pkg.sv */
`timescale 1ns / 1ps
package qta_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FIFO_DEPTH_DEF   = 2;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_ATTITUDE = 2'd1;
  localparam logic [1:0] OP_STAMP    = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_Z_ZERO = 2'd1;
  localparam logic [1:0] STATUS_Q_ZERO = 2'd2;

  localparam logic [14:0]        HALF_PI_Q13 = 15'd12868;
  localparam logic signed [14:0] ANGLE_MAX   = 15'sd12868;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [63:0]        stamp;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QMUL,
    S_RMUL,
    S_MAG,
    S_NORM,
    S_HSQ,
    S_SQRT,
    S_CORD,
    S_DONE
  } back_state_t;

  // atan(2^-i) in Q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'h3243F6A8;
      5'd1:  v = 31'h1DAC6705;
      5'd2:  v = 31'h0FADBAFC;
      5'd3:  v = 31'h07F56EA6;
      5'd4:  v = 31'h03FEAB76;
      5'd5:  v = 31'h01FFD55B;
      5'd6:  v = 31'h00FFFAAA;
      5'd7:  v = 31'h007FFF55;
      5'd8:  v = 31'h003FFFEA;
      5'd9:  v = 31'h001FFFFD;
      5'd10: v = 31'h000FFFFF;
      5'd11: v = 31'h0007FFFF;
      5'd12: v = 31'h0003FFFF;
      5'd13: v = 31'h0001FFFF;
      5'd14: v = 31'h0000FFFF;
      5'd15: v = 31'h00007FFF;
      5'd16: v = 31'h00003FFF;
      5'd17: v = 31'h00001FFF;
      5'd18: v = 31'h00000FFF;
      5'd19: v = 31'h000007FF;
      5'd20: v = 31'h000003FF;
      5'd21: v = 31'h000001FF;
      5'd22: v = 31'h000000FF;
      5'd23: v = 31'h0000007F;
      5'd24: v = 31'h0000003F;
      5'd25: v = 31'h0000001F;
      5'd26: v = 31'h0000000F;
      5'd27: v = 31'h00000008;
      5'd28: v = 31'h00000004;
      5'd29: v = 31'h00000002;
      5'd30: v = 31'h00000001;
      5'd31: v = 31'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/qta_if.sv */
`timescale 1ns / 1ps
interface qta_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [63:0]        time_stamp;

  modport source (output valid, opcode, quat_w, quat_x, quat_y, quat_z,
                  pos_x, pos_y, pos_z, time_stamp, input ready);
  modport sink (input valid, opcode, quat_w, quat_x, quat_y, quat_z,
                pos_x, pos_y, pos_z, time_stamp, output ready);
endinterface

interface qta_angles_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] angle_x;
  logic signed [14:0] angle_y;
  logic signed [14:0] angle_tilt;
  logic [63:0]        stamp_out;
  logic [1:0]         status;

  modport source (output valid, angle_x, angle_y, angle_tilt, stamp_out, status,
                  input ready);
  modport sink (input valid, angle_x, angle_y, angle_tilt, stamp_out, status,
                output ready);
endinterface

/* rtl/core/qta_fifo.sv */
`timescale 1ns / 1ps
module qta_fifo #(
  parameter int DEPTH = qta_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  qta_pkg::job_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output qta_pkg::job_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qta_pkg::job_t   mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/qta_front.sv */
`timescale 1ns / 1ps
module qta_front (
  input  logic          clk,
  input  logic          rst,
  qta_cmd_if.sink       cmd,
  output qta_pkg::job_t push_data,
  output logic          push_valid,
  input  logic          push_ready
);

  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [63:0]        stamp;
  logic               seen;
  logic               take;

  assign cmd.ready  = push_ready;
  assign take       = cmd.valid && cmd.ready;
  assign push_valid = cmd.valid && seen && (cmd.opcode == qta_pkg::OP_ATTITUDE);

  always_comb begin
    push_data.w     = cmd.quat_w;
    push_data.x     = cmd.quat_x;
    push_data.y     = cmd.quat_y;
    push_data.z     = cmd.quat_z;
    push_data.px    = pos_x;
    push_data.py    = pos_y;
    push_data.pz    = pos_z;
    push_data.stamp = stamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= 1'b0;
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      stamp <= '0;
    end else if (take) begin
      if (cmd.opcode == qta_pkg::OP_LOAD) begin
        pos_x <= cmd.pos_x;
        pos_y <= cmd.pos_y;
        pos_z <= cmd.pos_z;
        seen  <= 1'b1;
      end else if (cmd.opcode == qta_pkg::OP_STAMP) begin
        stamp <= cmd.time_stamp;
      end
    end
  end

endmodule

/* rtl/core/qta_back.sv */
`timescale 1ns / 1ps
module qta_back #(
  parameter int CORDIC_STEPS = qta_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  qta_pkg::job_t pop_data,
  input  logic          pop_valid,
  output logic          pop_ready,
  qta_angles_if.source  angles
);

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  qta_pkg::back_state_t state, state_next;
  qta_pkg::job_t        job;

  logic [3:0]         cnt;
  logic [1:0]         row, col, prow, pcol;
  logic signed [31:0] qp [10];
  logic signed [33:0] e [10];
  logic signed [31:0] m [9];
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] prod;
  logic signed [63:0] r [3];
  logic [63:0]        mag [3];
  logic [63:0]        mx;
  logic [2:0]         rneg, rzero;
  logic [63:0]        hs, sv, res, bitv, trial;
  logic [4:0]         bidx, step;
  logic [1:0]         sel;
  logic signed [35:0] cx, cy, xs, ys, cx_next, cy_next, x_load, y_load;
  logic signed [33:0] acc, acc_next;
  logic signed [34:0] rnd;
  logic [17:0]        rnd_q;
  logic [14:0]        ang_round;
  logic [14:0]        ang [3];
  logic               qzero, quat_zero_in, go_out;

  logic               ovalid;
  logic [14:0]        ox, oy, ot;
  logic [63:0]        ostamp;
  logic [1:0]         ostatus;

  function automatic logic signed [31:0] sh2(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v >>> 2;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] sh1(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v >>> 1;
    return t[31:0];
  endfunction

  function automatic logic [14:0] sangle(input logic nz, input logic neg,
                                         input logic zz, input logic zn,
                                         input logic [14:0] a);
    logic [14:0] v;
    v = zz ? qta_pkg::HALF_PI_Q13 : a;
    if (nz) begin
      return '0;
    end
    return (neg != (zn && !zz)) ? (~v + 15'd1) : v;
  endfunction

  assign quat_zero_in = (pop_data.w == '0) && (pop_data.x == '0) &&
                        (pop_data.y == '0) && (pop_data.z == '0);
  assign pop_ready    = (state == qta_pkg::S_IDLE);
  assign go_out       = !ovalid || angles.ready;

  // rotation matrix from the registered quaternion products
  always_comb begin
    for (int k = 0; k < 10; k++) begin
      e[k] = {{2{qp[k][31]}}, qp[k]};
    end
    m[0] = sh2(e[0] + e[1] - e[2] - e[3]);
    m[1] = sh1(e[4] - e[5]);
    m[2] = sh1(e[6] + e[7]);
    m[3] = sh1(e[4] + e[5]);
    m[4] = sh2(e[0] - e[1] + e[2] - e[3]);
    m[5] = sh1(e[8] - e[9]);
    m[6] = sh1(e[6] - e[7]);
    m[7] = sh1(e[8] + e[9]);
    m[8] = sh2(e[0] - e[1] - e[2] + e[3]);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      qta_pkg::S_QMUL: begin
        unique case (cnt)
          4'd0:    begin mul_a = 32'(job.w); mul_b = 32'(job.w); end
          4'd1:    begin mul_a = 32'(job.x); mul_b = 32'(job.x); end
          4'd2:    begin mul_a = 32'(job.y); mul_b = 32'(job.y); end
          4'd3:    begin mul_a = 32'(job.z); mul_b = 32'(job.z); end
          4'd4:    begin mul_a = 32'(job.x); mul_b = 32'(job.y); end
          4'd5:    begin mul_a = 32'(job.w); mul_b = 32'(job.z); end
          4'd6:    begin mul_a = 32'(job.x); mul_b = 32'(job.z); end
          4'd7:    begin mul_a = 32'(job.w); mul_b = 32'(job.y); end
          4'd8:    begin mul_a = 32'(job.y); mul_b = 32'(job.z); end
          4'd9:    begin mul_a = 32'(job.w); mul_b = 32'(job.x); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      qta_pkg::S_RMUL: begin
        mul_a = (cnt < 4'd9) ? m[cnt] : '0;
        unique case (col)
          2'd0:    mul_b = job.px;
          2'd1:    mul_b = job.py;
          default: mul_b = job.pz;
        endcase
      end
      qta_pkg::S_HSQ: begin
        mul_a = (cnt == 4'd0) ? mag[0][31:0] : mag[1][31:0];
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  assign bitv  = 64'd1 << {bidx, 1'b0};
  assign trial = res + bitv;

  // one vectoring step
  always_comb begin
    xs = cx >>> step;
    ys = cy >>> step;
    if (cy > 36'sd0) begin
      cx_next  = cx + ys;
      cy_next  = cy - xs;
      acc_next = acc + {3'b000, qta_pkg::atan_q30(step)};
    end else begin
      cx_next  = cx - ys;
      cy_next  = cy + xs;
      acc_next = acc - {3'b000, qta_pkg::atan_q30(step)};
    end
    rnd   = {acc_next[33], acc_next} + 35'sd65536;
    rnd_q = rnd[34:17];
    if (acc_next[33]) begin
      ang_round = '0;
    end else if (rnd_q > 18'd12868) begin
      ang_round = qta_pkg::HALF_PI_Q13;
    end else begin
      ang_round = rnd_q[14:0];
    end
  end

  assign x_load = {6'b0, mag[2][29:0]};
  assign y_load = (sel == 2'd0) ? {6'b0, mag[1][29:0]} : {5'b0, res[30:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qta_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qta_pkg::S_IDLE: begin
        if (pop_valid) begin
          state_next = quat_zero_in ? qta_pkg::S_DONE : qta_pkg::S_QMUL;
        end
      end
      qta_pkg::S_QMUL: if (cnt == 4'd10) state_next = qta_pkg::S_RMUL;
      qta_pkg::S_RMUL: if (cnt == 4'd9) state_next = qta_pkg::S_MAG;
      qta_pkg::S_MAG:  state_next = qta_pkg::S_NORM;
      qta_pkg::S_NORM: if (mx[63:30] == '0) state_next = qta_pkg::S_HSQ;
      qta_pkg::S_HSQ:  if (cnt == 4'd2) state_next = qta_pkg::S_SQRT;
      qta_pkg::S_SQRT: if (bidx == 5'd0) state_next = qta_pkg::S_CORD;
      qta_pkg::S_CORD: begin
        if (step == LAST_STEP && sel == 2'd2) state_next = qta_pkg::S_DONE;
      end
      qta_pkg::S_DONE: if (go_out) state_next = qta_pkg::S_IDLE;
      default: state_next = qta_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    unique case (state)
      qta_pkg::S_IDLE: begin
        if (pop_valid) begin
          job   <= pop_data;
          qzero <= quat_zero_in;
          cnt   <= '0;
          row   <= '0;
          col   <= '0;
        end
      end
      qta_pkg::S_QMUL: begin
        if (cnt != 4'd0) begin
          qp[4'(cnt - 4'd1)] <= prod[31:0];
        end
        cnt <= (cnt == 4'd10) ? 4'd0 : cnt + 4'd1;
      end
      qta_pkg::S_RMUL: begin
        if (cnt < 4'd9) begin
          prow <= row;
          pcol <= col;
          if (col == 2'd2) begin
            col <= '0;
            row <= row + 2'd1;
          end else begin
            col <= col + 2'd1;
          end
        end
        if (cnt != 4'd0) begin
          r[prow] <= (pcol == 2'd0) ? prod : r[prow] + prod;
        end
        cnt <= (cnt == 4'd9) ? 4'd0 : cnt + 4'd1;
      end
      qta_pkg::S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          rneg[i]  <= r[i][63];
          rzero[i] <= (r[i] == '0);
          mag[i]   <= r[i][63] ? 64'(~r[i] + 64'sd1) : 64'(r[i]);
        end
      end
      qta_pkg::S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mx[63:38] != '0) begin
            mag[i] <= mag[i] >> 8;
          end else if (mx[63:30] != '0) begin
            mag[i] <= mag[i] >> 1;
          end
        end
      end
      qta_pkg::S_HSQ: begin
        if (cnt == 4'd1) begin
          hs <= prod;
        end
        if (cnt == 4'd2) begin
          sv   <= hs + 64'(prod);
          res  <= '0;
          bidx <= 5'd31;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 4'd1;
        end
      end
      qta_pkg::S_SQRT: begin
        if (sv >= trial) begin
          sv  <= sv - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bidx <= bidx - 5'd1;
        if (bidx == 5'd0) begin
          cx   <= x_load;
          cy   <= {6'b0, mag[0][29:0]};
          acc  <= '0;
          step <= '0;
          sel  <= '0;
        end
      end
      qta_pkg::S_CORD: begin
        if (step == LAST_STEP) begin
          ang[sel] <= ang_round;
          if (sel != 2'd2) begin
            sel  <= sel + 2'd1;
            cx   <= x_load;
            cy   <= y_load;
            acc  <= '0;
            step <= '0;
          end
        end else begin
          cx   <= cx_next;
          cy   <= cy_next;
          acc  <= acc_next;
          step <= step + 5'd1;
        end
      end
      qta_pkg::S_DONE: begin
        if (go_out) begin
          ostamp <= job.stamp;
          if (qzero) begin
            ox      <= '0;
            oy      <= '0;
            ot      <= '0;
            ostatus <= qta_pkg::STATUS_Q_ZERO;
          end else begin
            ox      <= sangle(rzero[0], rneg[0], rzero[2], rneg[2], ang[0]);
            oy      <= sangle(rzero[1], rneg[1], rzero[2], rneg[2], ang[1]);
            ot      <= sangle(rzero[0] && rzero[1], 1'b0, rzero[2], rneg[2], ang[2]);
            ostatus <= rzero[2] ? qta_pkg::STATUS_Z_ZERO : qta_pkg::STATUS_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == qta_pkg::S_DONE && go_out) begin
      ovalid <= 1'b1;
    end else if (angles.ready) begin
      ovalid <= 1'b0;
    end
  end

  assign angles.valid      = ovalid;
  assign angles.angle_x    = ox;
  assign angles.angle_y    = oy;
  assign angles.angle_tilt = ot;
  assign angles.stamp_out  = ostamp;
  assign angles.status     = ostatus;

endmodule

/* rtl/core/quaternion_tilt_angles.sv */
`timescale 1ns / 1ps
// Tilt angles of a suspended load seen from a drone.
// cmd: one transaction per item. Opcode load stores the position, opcode
//   stamp stores the time stamp, opcode attitude rotates the stored position
//   by the quaternion. Other opcodes are dropped. All opcodes are taken while
//   the job queue has room.
// angles: one transaction per attitude item that arrives after a position,
//   carrying atan(x/z), atan(y/z), atan(sqrt(x^2+y^2)/z) in Q2.13, the stamp
//   that was current when the attitude arrived, and a status code.
// A job runs in turn through the one shared 32x32 multiplier, the shift
//   search, the bit-per-cycle square root and the CORDIC unit that runs
//   the three angles one after another; a zero quaternion goes straight
//   to the result. One job is worked at a time.
// A FIFO_DEPTH-entry queue sits between intake and the arithmetic engine, so
//   loads and stamps keep being taken during a job while the queue has room.
// Reset clears position, stamp, the seen flag, the queue and the output valid flag.
// A stalled receiver holds the result in the output register; the engine
//   waits only when a new result is ready and the register is still full.
`include "quaternion_tilt_angles_defines.svh"
module quaternion_tilt_angles #(
  parameter int CORDIC_STEPS = qta_pkg::CORDIC_STEPS_DEF,
  parameter int FIFO_DEPTH   = qta_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  qta_cmd_if.sink      cmd,
  qta_angles_if.source angles
);

  qta_pkg::job_t push_data;
  logic          push_valid;
  logic          push_ready;
  qta_pkg::job_t pop_data;
  logic          pop_valid;
  logic          pop_ready;

  qta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  qta_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  qta_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .angles    (angles)
  );

  `QTA_ASSERT(a_pop_leaves_idle, pop_valid && pop_ready |=> !pop_ready, "engine idle after job")
  `QTA_ASSERT(a_result_from_busy, $rose(angles.valid) |-> !$past(pop_ready), "result from idle")
  `QTA_ASSERT(a_qzero_angles, angles.valid && angles.status == qta_pkg::STATUS_Q_ZERO |-> angles.angle_x == '0 && angles.angle_y == '0 && angles.angle_tilt == '0, "zero quaternion angles")
  `QTA_NEVER(a_angle_range, angles.valid && (angles.angle_tilt > qta_pkg::ANGLE_MAX || angles.angle_tilt < -qta_pkg::ANGLE_MAX || angles.angle_x > qta_pkg::ANGLE_MAX || angles.angle_x < -qta_pkg::ANGLE_MAX), "angle out of range")

endmodule

/* tb/quaternion_tilt_angles_tb.sv */
`timescale 1ns / 1ps
module quaternion_tilt_angles_tb;

  localparam int STEPS = qta_pkg::CORDIC_STEPS_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [14:0] ax;
    logic signed [14:0] ay;
    logic signed [14:0] at;
    logic [63:0]        stamp;
    logic [1:0]         status;
  } angles_t;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] w, x, y, z;
    logic signed [31:0] px, py, pz;
    logic [63:0]        stamp;
  } cmd_t;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_atan(longint dx, longint ny);
    longint xv, yv, acc, xs, ys, r;
    xv = dx;
    yv = ny;
    acc = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = fshr(xv, i);
      ys = fshr(yv, i);
      if (yv > 0) begin
        xv = xv + ys; yv = yv - xs; acc += longint'(qta_pkg::atan_q30(i[4:0]));
      end else begin
        xv = xv - ys; yv = yv + xs; acc -= longint'(qta_pkg::atan_q30(i[4:0]));
      end
    end
    if (acc < 0) return 0;
    r = (acc + 65536) >>> 17;
    return (r > 12868) ? 12868 : r;
  endfunction

  function automatic longint tilt_of(bit nz, bit nneg, longint unsigned n, bit zz, bit zneg,
                                     longint unsigned zm);
    longint a;
    if (nz) return 0;
    a = zz ? 12868 : vector_atan(longint'(zm), longint'(n));
    return (nneg != (zneg && !zz)) ? -a : a;
  endfunction

  class tilt_scoreboard;
    logic signed [31:0] pos[3];
    bit                 have_pos;
    logic [63:0]        stamp = '0;
    angles_t            pending[$];
    int                 errors;

    function void note_cmd(cmd_t c);
      longint w, qx, qy, qz, m[9], r[3];
      longint unsigned mag[3], mx, hor;
      int s;
      angles_t e;
      if (c.op == qta_pkg::OP_LOAD) begin
        pos[0] = c.px; pos[1] = c.py; pos[2] = c.pz;
        have_pos = 1;
        return;
      end
      if (c.op == qta_pkg::OP_STAMP) begin
        stamp = c.stamp;
        return;
      end
      if (c.op != qta_pkg::OP_ATTITUDE || !have_pos) return;
      e = '0;
      e.stamp = stamp;
      w = c.w; qx = c.x; qy = c.y; qz = c.z;
      if (w == 0 && qx == 0 && qy == 0 && qz == 0) begin
        e.status = qta_pkg::STATUS_Q_ZERO;
      end else begin
        m[0] = w*w + qx*qx - qy*qy - qz*qz;
        m[1] = 2*(qx*qy - w*qz);
        m[2] = 2*(qx*qz + w*qy);
        m[3] = 2*(qx*qy + w*qz);
        m[4] = w*w - qx*qx + qy*qy - qz*qz;
        m[5] = 2*(qy*qz - w*qx);
        m[6] = 2*(qx*qz - w*qy);
        m[7] = 2*(qy*qz + w*qx);
        m[8] = w*w - qx*qx - qy*qy + qz*qz;
        for (int i = 0; i < 9; i++) m[i] = fshr(m[i], 2);
        for (int i = 0; i < 3; i++) begin
          r[i] = m[3*i]*longint'(pos[0]) + m[3*i+1]*longint'(pos[1])
               + m[3*i+2]*longint'(pos[2]);
          mag[i] = (r[i] < 0) ? longint'(-r[i]) : r[i];
        end
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        s = 0;
        while ((mx >> s) >= (64'd1 << 30)) s++;
        hor = sqrt_floor((mag[0] >> s)*(mag[0] >> s) + (mag[1] >> s)*(mag[1] >> s));
        e.status = (r[2] == 0) ? qta_pkg::STATUS_Z_ZERO : qta_pkg::STATUS_OK;
        e.ax = 15'(tilt_of(r[0] == 0, r[0] < 0, mag[0] >> s, r[2] == 0, r[2] < 0, mag[2] >> s));
        e.ay = 15'(tilt_of(r[1] == 0, r[1] < 0, mag[1] >> s, r[2] == 0, r[2] < 0, mag[2] >> s));
        e.at = 15'(tilt_of(r[0] == 0 && r[1] == 0, 0, hor, r[2] == 0, r[2] < 0,
                           mag[2] >> s));
      end
      pending.push_back(e);
    endfunction

    function void check_angles(angles_t got);
      angles_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected angles transaction %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: ax %0d/%0d ay %0d/%0d tilt %0d/%0d stamp %h/%h status %0d/%0d",
                   e.ax, got.ax, e.ay, got.ay, e.at, got.at, e.stamp, got.stamp,
                   e.status, got.status);
      end
    endfunction
  endclass

  logic clk, rst;
  qta_cmd_if    cmd();
  qta_angles_if angles();

  quaternion_tilt_angles u_dut (.clk(clk), .rst(rst), .cmd(cmd.sink), .angles(angles.source));

  tilt_scoreboard sb;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(120, 20);
  endfunction

  task automatic send_cmd(cmd_t c);
    cmd.opcode = c.op;
    cmd.quat_w = c.w; cmd.quat_x = c.x; cmd.quat_y = c.y; cmd.quat_z = c.z;
    cmd.pos_x = c.px; cmd.pos_y = c.py; cmd.pos_z = c.pz;
    cmd.time_stamp = c.stamp;
    cmd.valid = 1'b1;
    do @(posedge clk); while (!cmd.ready);
    sb.note_cmd(c);
    @(negedge clk);
    cmd.valid = 1'b0;
  endtask

  task automatic idle_gap(bit stretch);
    int n;
    n = stretch ? 0 : gap_len();
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_q();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'($signed($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_p();
    case ($urandom_range(6))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return 32'($signed($urandom_range(2000)) - 1000);
      4: return 32'($signed($urandom_range(20'hFFFFF)) - 20'sh80000);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic cmd_t rand_cmd(logic [1:0] op);
    cmd_t c;
    c.op = op;
    c.w = rand_q(); c.x = rand_q(); c.y = rand_q(); c.z = rand_q();
    if ($urandom_range(9) == 0) begin
      c.w = 0; c.x = 0; c.y = 0; c.z = 0;
    end
    c.px = rand_p(); c.py = rand_p(); c.pz = rand_p();
    c.stamp = {$urandom, $urandom};
    return c;
  endfunction

  function automatic cmd_t mk(logic [1:0] op, int w, int x, int y, int z,
                              int px, int py, int pz);
    cmd_t c;
    c = rand_cmd(op);
    c.w = 16'(w); c.x = 16'(x); c.y = 16'(y); c.z = 16'(z);
    c.px = px; c.py = py; c.pz = pz;
    return c;
  endfunction

  initial begin
    sb = new();
    angles.ready = 1'b0;
    forever begin
      @(negedge clk);
      angles.ready <= ($urandom_range(3) != 0) || (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && angles.valid && angles.ready)
      sb.check_angles('{angles.angle_x, angles.angle_y, angles.angle_tilt,
                         angles.stamp_out, angles.status});
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (angles.valid && angles.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("** quaternion_tilt_angles: FAILED **");
      $finish;
    end
  end

  initial begin
    cmd_t c;
    int op;
    bit stretch;
    rst = 1'b1;
    idle_cycles = 0;
    cmd.valid = 1'b0;
    cmd.opcode = qta_pkg::OP_LOAD;
    cmd.quat_w = 0; cmd.quat_x = 0; cmd.quat_y = 0; cmd.quat_z = 0;
    cmd.pos_x = 0; cmd.pos_y = 0; cmd.pos_z = 0;
    cmd.time_stamp = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // attitude before any position: no result
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 16384, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(2'd3, 1, 2, 3, 4, 5, 6, 7));
    c = rand_cmd(qta_pkg::OP_STAMP); c.stamp = '1; send_cmd(c);
    send_cmd(mk(qta_pkg::OP_LOAD, 0, 0, 0, 0, 65536, -65536, 131072));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 32767, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, -32768, -32768, -32768, -32768, 0, 0, 0));
    c = rand_cmd(qta_pkg::OP_STAMP); c.stamp = 0; send_cmd(c);
    send_cmd(mk(qta_pkg::OP_LOAD, 0, 0, 0, 0, 65536, 0, 0));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 16384, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 16384, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_LOAD, 0, 0, 0, 0, 0, -5, 0));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 16384, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_LOAD, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 32767, 32767, -32768, 32767, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, -65536));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 16384, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(qta_pkg::OP_ATTITUDE, 0, 16384, 0, 0, 0, 0, 0));

    // hold off until the engine drains
    while (sb.pending.size() != 0) @(negedge clk);

    stretch = 0;
    for (int n = 0; n < 1250; n++) begin
      if (n % 200 == 100) stretch = ~stretch;
      op = $urandom_range(99);
      if (op < 25) c = rand_cmd(qta_pkg::OP_LOAD);
      else if (op < 35) c = rand_cmd(qta_pkg::OP_STAMP);
      else if (op < 97) c = rand_cmd(qta_pkg::OP_ATTITUDE);
      else c = rand_cmd(2'd3);
      send_cmd(c);
      idle_gap(stretch);
      if (n == 600)
        while (sb.pending.size() != 0) @(negedge clk);
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** quaternion_tilt_angles: PASSED **");
    else
      $display("** quaternion_tilt_angles: FAILED **");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/qta_pkg.sv
rtl/core/qta_if.sv
rtl/core/qta_fifo.sv
rtl/core/qta_front.sv
rtl/core/qta_back.sv
rtl/core/quaternion_tilt_angles.sv
tb/quaternion_tilt_angles_tb.sv
